FILE: hdl/ikl_pkg.sv
// Shared types, codes and helper functions for the IR keypad time-code lock.
// No dependencies; the controller, datapath and top level refer to this package by scoped names.
package ikl_pkg;

  typedef logic [2:0] ev_t;
  typedef logic [3:0] key_t;

  localparam ev_t EV_NONE     = 3'd0;
  localparam ev_t EV_PRESS    = 3'd1;
  localparam ev_t EV_RELEASE  = 3'd2;
  localparam ev_t EV_LOCKED   = 3'd3;
  localparam ev_t EV_SEED     = 3'd4;
  localparam ev_t EV_MISMATCH = 3'd5;
  localparam ev_t EV_UNLOCKED = 3'd6;
  localparam ev_t EV_IGNORED  = 3'd7;

  localparam key_t KEY_LOCK = 4'd10;
  localparam key_t KEY_NONE = 4'd11;

  localparam logic [15:0] WINDOW_RESET = 16'd60;
  localparam logic [15:0] HASH_MUL_A   = 16'd654;
  localparam logic [15:0] HASH_MUL_B   = 16'd54323;

  // Radix-16 restoring divider: four quotient bits per step over 64 dividend bits.
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = 64 / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mul1;
    logic mul2;
    logic commit;
  } ikl_cmd_t;

  typedef struct packed {
    logic need_code;
    logic div_last;
    logic out_free;
  } ikl_stat_t;

  function automatic key_t key_of(input logic [63:0] c);
    key_t k;
    case (c)
      64'hfffbfffefafefa00: k = 4'd0;
      64'hfffbfffffefffef8: k = 4'd1;
      64'hfffbfffefefefec0: k = 4'd2;
      64'hfffbffffbeffbec0: k = 4'd3;
      64'hfffbfffebefebe00: k = 4'd4;
      64'hfffbffffeeffeec0: k = 4'd5;
      64'hfffbfffeeefeee00: k = 4'd6;
      64'hfffbffffaeffae00: k = 4'd7;
      64'hfffbfffeaefea000: k = 4'd8;
      64'hfffbfffffafffac0: k = 4'd9;
      64'hfffbfffefbeefb00: k = KEY_LOCK;
      default:              k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] fold16(input logic [31:0] x);
    return x[15:0] ^ x[31:16];
  endfunction

  // Force each nibble above nine into the decimal range by masking with nine.
  function automatic logic [15:0] bcd_fix(input logic [15:0] p);
    logic [15:0] r;
    r = p;
    for (int i = 0; i < 4; i++) begin
      if (p[4*i +: 4] > 4'd9) begin
        r[4*i +: 4] = p[4*i +: 4] & 4'h9;
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/ikl_in_if.sv
// Input channel of the IR keypad time-code lock: valid/ready plus one poll word.
// No dependencies.
interface ikl_in_if;
  logic        valid;
  logic        ready;
  logic        button_level;
  logic [63:0] ir_code;
  logic [31:0] time_seconds;

  modport source (output valid, button_level, ir_code, time_seconds, input ready);
  modport sink   (input valid, button_level, ir_code, time_seconds, output ready);
endinterface

FILE: hdl/ikl_out_if.sv
// Result channel of the IR keypad time-code lock: valid/ready plus one result word.
// No dependencies.
interface ikl_out_if;
  logic        valid;
  logic        ready;
  logic        locked_flag;
  logic        led_on;
  logic [15:0] entered_code;
  logic [2:0]  event_res;

  modport source (output valid, locked_flag, led_on, entered_code, event_res, input ready);
  modport sink   (input valid, locked_flag, led_on, entered_code, event_res, output ready);
endinterface

FILE: hdl/ikl_ctrl.sv
// Sequencing state machine of the IR keypad time-code lock.
// Depends on ikl_pkg for the command and status structs.
module ikl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ikl_pkg::ikl_stat_t stat,
  output ikl_pkg::ikl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MUL1   = 3'd3;
  localparam logic [2:0] S_MUL2   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.need_code) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register can take the word
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/ikl_dp.sv
// Datapath of the IR keypad time-code lock: lock state, divider, hash and result register.
// Depends on ikl_pkg for codes, helper functions and the command/status structs.
module ikl_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ikl_pkg::ikl_cmd_t  cmd,
  output ikl_pkg::ikl_stat_t stat,
  input  logic [15:0]        window,
  input  logic               in_button_level,
  input  logic [63:0]        in_ir_code,
  input  logic [31:0]        in_time_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_locked_flag,
  output logic               out_led_on,
  output logic [15:0]        out_entered_code,
  output logic [2:0]         out_event_res
);

  // architectural state
  logic        locked_r, locked_nxt;
  logic        held_r, held_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [15:0] entry_r, entry_nxt;

  // captured poll
  logic        btn_r;
  logic [63:0] ir_r;
  logic [31:0] now_r;

  // divider and hash
  logic [63:0]                   dvd_r;
  logic [15:0]                   rem_r;
  logic [31:0]                   quo_r;
  logic [ikl_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [15:0]                   ha_r, hb_r, code_r;

  // result register
  logic        ovld_r;
  logic        olock_r;
  logic [15:0] oshown_r;
  logic [2:0]  oev_r;

  logic [15:0]        w_eff;
  logic [16:0]        rem_step;
  logic [ikl_pkg::DIV_BITS-1:0] qbits;
  logic [63:0]        t_val;
  logic [31:0]        prod_ab;
  ikl_pkg::key_t      key;
  logic               press, release_e;
  logic [15:0]        or_val, shown;
  ikl_pkg::ev_t       ev;

  assign w_eff = (window == 16'd0) ? 16'd1 : window;
  assign key   = ikl_pkg::key_of(ir_r);
  assign press     = btn_r && !held_r && !locked_r;
  assign release_e = !btn_r && held_r && !locked_r;
  assign or_val    = entry_r | {12'd0, key};

  assign stat.need_code = !press && !release_e && (key < ikl_pkg::KEY_LOCK)
                          && !held_r && locked_r;
  assign stat.div_last  = (cnt_r == ikl_pkg::DIV_CNT_W'(ikl_pkg::DIV_STEPS - 1));
  assign stat.out_free  = !ovld_r || out_ready;

  assign t_val = {32'd0, now_r} - {32'd0, offset_r} + seed_r;

  // four restoring steps per cycle, remainder stays below the window
  always_comb begin
    rem_step = {1'b0, rem_r};
    qbits    = '0;
    for (int i = 0; i < ikl_pkg::DIV_BITS; i++) begin
      rem_step = {rem_step[15:0], dvd_r[63-i]};
      if (rem_step >= {1'b0, w_eff}) begin
        rem_step = rem_step - {1'b0, w_eff};
        qbits[ikl_pkg::DIV_BITS-1-i] = 1'b1;
      end
    end
  end

  assign prod_ab = {16'd0, ha_r} * {16'd0, hb_r};

  // next architectural state for the captured poll
  always_comb begin
    locked_nxt = locked_r;
    held_nxt   = held_r;
    seed_nxt   = seed_r;
    offset_nxt = offset_r;
    entry_nxt  = entry_r;
    ev         = ikl_pkg::EV_NONE;
    shown      = 16'd0;
    if (press) begin
      seed_nxt = 64'd0;
      held_nxt = 1'b1;
      ev       = ikl_pkg::EV_PRESS;
    end else if (release_e) begin
      offset_nxt = now_r;
      held_nxt   = 1'b0;
      ev         = ikl_pkg::EV_RELEASE;
    end else if (key == ikl_pkg::KEY_NONE) begin
      ev = ikl_pkg::EV_NONE;
    end else if (key == ikl_pkg::KEY_LOCK) begin
      if (!locked_r) begin
        locked_nxt = 1'b1;
        entry_nxt  = 16'd0;
        ev         = ikl_pkg::EV_LOCKED;
      end else begin
        ev = ikl_pkg::EV_IGNORED;
      end
    end else if (held_r) begin
      seed_nxt = {seed_r[60:0], 3'd0} + {seed_r[62:0], 1'b0} + {60'd0, key};
      ev       = ikl_pkg::EV_SEED;
    end else if (!locked_r) begin
      ev = ikl_pkg::EV_IGNORED;
    end else if (or_val == code_r) begin
      locked_nxt = 1'b0;
      entry_nxt  = 16'd0;
      ev         = ikl_pkg::EV_UNLOCKED;
    end else begin
      entry_nxt = {or_val[11:0], 4'd0};
      ev        = ikl_pkg::EV_MISMATCH;
    end
    shown = stat.need_code ? or_val : entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      held_r   <= 1'b0;
      seed_r   <= 64'd0;
      offset_r <= 32'd0;
      entry_r  <= 16'd0;
      ovld_r   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        locked_r <= locked_nxt;
        held_r   <= held_nxt;
        seed_r   <= seed_nxt;
        offset_r <= offset_nxt;
        entry_r  <= entry_nxt;
        ovld_r   <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      btn_r <= in_button_level;
      ir_r  <= in_ir_code;
      now_r <= in_time_seconds;
    end
    if (cmd.div_start) begin
      dvd_r <= t_val;
      rem_r <= 16'd0;
      quo_r <= 32'd0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[63-ikl_pkg::DIV_BITS:0], {ikl_pkg::DIV_BITS{1'b0}}};
      rem_r <= rem_step[15:0];
      quo_r <= {quo_r[31-ikl_pkg::DIV_BITS:0], qbits};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul1) begin
      ha_r <= ikl_pkg::fold16(quo_r * {16'd0, ikl_pkg::HASH_MUL_A});
      hb_r <= ikl_pkg::fold16(quo_r * {16'd0, ikl_pkg::HASH_MUL_B});
    end
    if (cmd.mul2) begin
      code_r <= ikl_pkg::bcd_fix(ikl_pkg::fold16(prod_ab));
    end
    if (cmd.commit) begin
      olock_r  <= locked_nxt;
      oshown_r <= shown;
      oev_r    <= ev;
    end
  end

  assign out_valid        = ovld_r;
  assign out_locked_flag  = olock_r;
  assign out_led_on       = !olock_r;
  assign out_entered_code = oshown_r;
  assign out_event_res    = oev_r;

endmodule

FILE: hdl/ir_keypad_time_code_lock_core.sv
// IR keypad time-code lock, top level: APB window register, controller and datapath.
// Each word goes through the decide state to the finish state, which commits it to
// the result register; a locked digit first runs 16 steps of the radix-16 divider
// and two hash multiply stages. A stalled result waits in the finish state; no new word
// is taken until it is committed. Sync active-low reset unlocks, clears seed, offset,
// entry, and sets the window to 60 seconds. Depends on ikl_pkg, ikl_in_if, ikl_out_if.
module ir_keypad_time_code_lock_core (
  input  logic        clk,
  input  logic        rst_n,
  ikl_in_if.sink      in_ch,
  ikl_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ikl_pkg::ikl_cmd_t  cmd;
  ikl_pkg::ikl_stat_t stat;

  logic [15:0] window_r;
  logic        cfg_wr;

  // Register file: a single 16-bit window length at byte addresses zero to three.
  // Writes land on the access phase; addresses four to seven read as zero and drop writes.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {16'd0, window_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= ikl_pkg::WINDOW_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == 1'b0)) begin
      window_r <= cfg_pwdata[15:0];
    end
  end

  // Controller: take one word, decide whether the code is needed, step the
  // divider and hash, then hold until the result register frees up.
  ikl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: lock state, quotient of (time - offset + seed) by the window,
  // xor-fold hash with decimal fix-up, and the output register that parts
  // the result side from the input side.
  ikl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .window           (window_r),
    .in_button_level  (in_ch.button_level),
    .in_ir_code       (in_ch.ir_code),
    .in_time_seconds  (in_ch.time_seconds),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_locked_flag  (out_ch.locked_flag),
    .out_led_on       (out_ch.led_on),
    .out_entered_code (out_ch.entered_code),
    .out_event_res    (out_ch.event_res)
  );

  // One word in flight: in the cycle after an accept the input side is closed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  // Indicator always drives the inverse of the lock flag.
  a_led_inverse: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.led_on != out_ch.locked_flag))
    else $error("led_on does not mirror locked_flag");

  // Engaging the lock reports a locked result with a cleared entry.
  a_lock_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.event_res == ikl_pkg::EV_LOCKED))
      |-> (out_ch.locked_flag && (out_ch.entered_code == 16'd0)))
    else $error("lock event without locked flag or with stale entry");

  // An unlock or a press/release always leaves the lock open.
  a_unlock_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((out_ch.event_res == ikl_pkg::EV_UNLOCKED)
      || (out_ch.event_res == ikl_pkg::EV_PRESS)
      || (out_ch.event_res == ikl_pkg::EV_RELEASE))) |-> !out_ch.locked_flag)
    else $error("open-lock event reported while locked");

endmodule
